@@ src/lmrs_pkg.sv @@
// Shared types, widths and constants of the LED-modulated reflectance scanner.
`default_nettype none

package lmrs_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int DARK_W      = 13;
	localparam int WEIGHT_W    = 8;
	localparam int PROD_W      = 21;
	localparam int DIVISOR_W   = 9;
	localparam int QUOT_W      = 13;
	localparam int CHAN_W      = 4;
	localparam int PHASE_W     = 8;
	localparam int PATTERN_W   = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * SAMPLE_W + 2 * CHAN_W + 1);

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_ALT  = 2'd2,
		MODE_LFSR = 2'd3
	} led_mode_t;

	localparam logic [CFG_INDEX_W-1:0] REG_LED_MODE      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WEIGHT = 2'd1;

	localparam led_mode_t              MODE_INIT    = MODE_ALT;
	localparam logic [WEIGHT_W-1:0]    WEIGHT_INIT  = 8'd7;
	localparam logic [PATTERN_W-1:0]   PATTERN_INIT = 4'h5;
	localparam logic [DARK_W-1:0]      DARK_INIT    = 13'd4096;
	localparam logic [SAMPLE_W-1:0]    CLIP_MAX     = 12'hFFF;

	// One channel's stored state, one RAM word.
	typedef struct packed {
		logic [DARK_W-1:0]   dark_s;
		logic [SAMPLE_W-1:0] lit_s;
		logic [DARK_W-1:0]   dark_a;
		logic [SAMPLE_W-1:0] lit_a;
	} chan_entry_t;

	localparam chan_entry_t ENTRY_INIT = '{
		dark_s: DARK_INIT,
		lit_s:  '0,
		dark_a: DARK_INIT,
		lit_a:  '0
	};

	typedef struct packed {
		logic [CHAN_W-1:0]   next_channel;
		logic                led_drive;
		logic                report_valid;
		logic [CHAN_W-1:0]   sensor_index;
		logic [SAMPLE_W-1:0] raw_difference;
		logic [SAMPLE_W-1:0] filtered_difference;
		logic                last;
	} out_item_t;

	// a - b clipped to 0..4095
	function automatic logic [SAMPLE_W-1:0] clip_diff(
		input logic [DARK_W-1:0] a,
		input logic [DARK_W-1:0] b
	);
		logic [DARK_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[DARK_W])
			return '0;
		else if (d[DARK_W-1])
			return CLIP_MAX;
		else
			return d[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/lmrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lmrs_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 10,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/lmrs_div.sv @@
// Restoring divider, one quotient bit per cycle; quotient known to fit QUOT_W bits.
`default_nettype none

module lmrs_div
	import lmrs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [PROD_W-1:0]    dividend,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      done,
	output logic [QUOT_W-1:0]         quotient
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [QUOT_W-1:0]    dvd_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 ge;
	logic [DIVISOR_W-1:0] rem_next;

	assign trial    = {rem_q, dvd_q[QUOT_W-1]};
	assign diff     = trial - {1'b0, dsr_q};
	assign ge       = trial >= {1'b0, dsr_q};
	assign rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// upper dividend bits start as the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIVISOR_W'(dividend[PROD_W-1:QUOT_W]);
			dvd_q <= dividend[QUOT_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[QUOT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < dsr_q))
		else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

@@ src/led_modulated_reflectance_scanner.sv @@
// Top level of the LED-modulated reflectance scanner.
//
// s_* : one 12-bit ADC conversion per request (s_tdata[11:0]).
// m_* : result requests; tdata holds next channel, LED drive, sensor index
//       and the clipped raw and filtered off-minus-on differences; tuser
//       flags a report, tlast marks the final result of an input request.
// cfg_*: register writes (0 led_mode, 1 filter_weight); ready is always high.
//       Writing led_mode returns scan state, pattern and channel RAM to reset.
// A scan is one start request, settling requests and one read per channel.
// The start request runs a filter pass: per channel, one RAM read, one
// multiply-add, two restoring divisions in parallel and a write back
// with a report. A read request runs a RAM read, a modify-write and an
// emit; a settling request only emits. One request is processed at a
// time; the input is taken whenever the sequencer is idle, even while a
// result waits in the output register; a stalled receiver holds the
// sequencer in its emit step, which holds back the input as well.
// Reset: led_mode 2, filter_weight 7, all channel entries read as reset
// values through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module led_modulated_reflectance_scanner
	import lmrs_pkg::*;
#(
	parameter int CHANNELS     = 10,
	parameter int SETTLE_STEPS = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] adc_sample

	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [3:0] next_channel, [4] led_drive, [8:5] sensor_index,
	// [20:9] raw_difference, [32:21] filtered_difference, rest zero
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tuser,   // [0] report_valid
	output logic                        m_tlast,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// sequencer
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_FRD    = 9'b000000010,   // filter pass: read entry
		ST_FMUL   = 9'b000000100,   // k*avg + sample
		ST_FSTART = 9'b000001000,
		ST_FDIV   = 9'b000010000,
		ST_FOUT   = 9'b000100000,   // write back, emit report
		ST_RRD    = 9'b001000000,   // read step: read entry
		ST_RWB    = 9'b010000000,   // read step: store sample
		ST_EMIT   = 9'b100000000    // single non-report result
	} state_t;

	state_t                state_q;
	led_mode_t             mode_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic [PHASE_W-1:0]    phase_q;
	logic [CHAN_W-1:0]     ch_q;
	logic                  led_q;
	logic [PATTERN_W-1:0]  pattern_q;
	logic [CHANNELS-1:0]   valid_q;
	logic [AW-1:0]         idx_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [SAMPLE_W-1:0]   sample_q;
	logic [PROD_W-1:0]     dark_num_s1;
	logic [PROD_W-1:0]     lit_num_s1;
	logic [DARK_W-1:0]     dark_s_s1;
	logic [SAMPLE_W-1:0]   lit_s_s1;

	// RAM ports
	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_waddr;
	logic [AW-1:0]         ram_raddr;
	chan_entry_t           ram_wdata;
	chan_entry_t           ram_rdata;

	logic [AW-1:0]         ch_addr;
	logic [AW-1:0]         cur_idx;
	chan_entry_t           cur_entry;
	chan_entry_t           fout_entry;
	chan_entry_t           rwb_entry;

	logic                  div_start;
	logic                  dark_done;
	logic                  lit_done;
	logic [QUOT_W-1:0]     dark_quot;
	logic [QUOT_W-1:0]     lit_quot;
	logic [DIVISOR_W-1:0]  divisor;

	logic                  in_acc;
	logic                  out_free;
	logic                  out_load;
	logic                  idx_last;
	logic                  ch_last;
	logic                  led_next;
	logic [PATTERN_W-1:0]  pattern_next;
	logic                  pat_bit;
	out_item_t             out_next;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign ch_addr  = ch_q[AW-1:0];
	assign idx_last = (idx_q == AW'(CHANNELS - 1));
	assign ch_last  = (ch_q == CHAN_W'(CHANNELS - 1));
	assign divisor  = {1'b0, weight_q} + 1'b1;

	// entries not written since reset or the last led_mode write read as their reset value
	assign cur_idx   = (state_q == ST_FMUL) ? idx_q : ch_addr;
	assign cur_entry = valid_q[cur_idx] ? ram_rdata : ENTRY_INIT;

	always_comb begin
		rwb_entry = cur_entry;
		if (led_q)
			rwb_entry.lit_s = sample_q;
		else
			rwb_entry.dark_s = {1'b0, sample_q};
	end

	assign fout_entry = '{
		dark_s: dark_s_s1,
		lit_s:  lit_s_s1,
		dark_a: dark_quot,
		lit_a:  lit_quot[SAMPLE_W-1:0]
	};

	assign ram_re    = (state_q == ST_FRD) || (state_q == ST_RRD);
	assign ram_raddr = (state_q == ST_FRD) ? idx_q : ch_addr;
	assign ram_we    = ((state_q == ST_FOUT) && out_free) || (state_q == ST_RWB);
	assign ram_waddr = (state_q == ST_FOUT) ? idx_q : ch_addr;
	assign ram_wdata = (state_q == ST_FOUT) ? fout_entry : rwb_entry;

	assign div_start = (state_q == ST_FSTART);

	// LED choice at scan start
	assign pat_bit = pattern_q[3] ^ pattern_q[2];
	always_comb begin
		unique case (mode_q)
			MODE_OFF: begin
				pattern_next = pattern_q;
				led_next     = 1'b0;
			end
			MODE_ON: begin
				pattern_next = pattern_q;
				led_next     = 1'b1;
			end
			MODE_ALT: begin
				pattern_next = pattern_q + 1'b1;
				led_next     = pattern_next[0];
			end
			MODE_LFSR: begin
				pattern_next = {pattern_q[PATTERN_W-2:0], pat_bit};
				led_next     = pat_bit;
			end
			default: begin
				pattern_next = pattern_q;
				led_next     = 1'b0;
			end
		endcase
	end

	// output register
	assign out_load = ((state_q == ST_FOUT) || (state_q == ST_EMIT)) && out_free;
	always_comb begin
		out_next              = '0;
		out_next.next_channel = ch_q;
		out_next.led_drive    = led_q;
		out_next.last         = 1'b1;
		if (state_q == ST_FOUT) begin
			out_next.report_valid        = 1'b1;
			out_next.sensor_index        = CHAN_W'(idx_q);
			out_next.raw_difference      = clip_diff(dark_s_s1, {1'b0, lit_s_s1});
			out_next.filtered_difference = clip_diff(dark_quot,
				{1'b0, lit_quot[SAMPLE_W-1:0]});
			out_next.last                = idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_INIT;
			weight_q    <= WEIGHT_INIT;
			phase_q     <= '0;
			ch_q        <= '0;
			led_q       <= 1'b0;
			pattern_q   <= PATTERN_INIT;
			valid_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						priority if (phase_q == '0) begin
							led_q     <= led_next;
							pattern_q <= pattern_next;
							ch_q      <= '0;
							phase_q   <= PHASE_W'(1);
							idx_q     <= '0;
							state_q   <= ST_FRD;
						end else if (phase_q < PHASE_W'(SETTLE_STEPS)) begin
							phase_q <= phase_q + 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_RRD;
						end
					end
				end
				ST_FRD:    state_q <= ST_FMUL;
				ST_FMUL:   state_q <= ST_FSTART;
				ST_FSTART: state_q <= ST_FDIV;
				ST_FDIV: begin
					if (dark_done)
						state_q <= ST_FOUT;
				end
				ST_FOUT: begin
					if (out_free) begin
						valid_q[idx_q] <= 1'b1;
						if (idx_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_FRD;
						end
					end
				end
				ST_RRD: state_q <= ST_RWB;
				ST_RWB: begin
					valid_q[ch_addr] <= 1'b1;
					if (ch_last) begin
						ch_q    <= '0;
						phase_q <= '0;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// the user must send configuration only while idle; the block does not enforce it
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LED_MODE) begin
					mode_q    <= led_mode_t'(cfg_data[1:0]);
					phase_q   <= '0;
					ch_q      <= '0;
					led_q     <= 1'b0;
					pattern_q <= PATTERN_INIT;
					valid_q   <= '0;
				end else if (cfg_index == REG_FILTER_WEIGHT) begin
					weight_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			sample_q <= s_tdata[SAMPLE_W-1:0];
		if (state_q == ST_FMUL) begin
			dark_num_s1 <= PROD_W'(weight_q) * PROD_W'(cur_entry.dark_a)
				+ PROD_W'(cur_entry.dark_s);
			lit_num_s1  <= PROD_W'(weight_q) * PROD_W'(cur_entry.lit_a)
				+ PROD_W'(cur_entry.lit_s);
			dark_s_s1   <= cur_entry.dark_s;
			lit_s_s1    <= cur_entry.lit_s;
		end
		if (out_load)
			out_q <= out_next;
	end

	lmrs_ram #(
		.WIDTH ($bits(chan_entry_t)),
		.DEPTH (CHANNELS)
	) u_chan_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lmrs_div u_dark_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dark_num_s1),
		.divisor  (divisor),
		.done     (dark_done),
		.quotient (dark_quot)
	);

	lmrs_div u_lit_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lit_num_s1),
		.divisor  (divisor),
		.done     (lit_done),
		.quotient (lit_quot)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.report_valid;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {
		{OUT_PAD_W{1'b0}},
		out_q.filtered_difference,
		out_q.raw_difference,
		out_q.sensor_index,
		out_q.led_drive,
		out_q.next_channel
	};

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ch_q} < (CHAN_W + 1)'(CHANNELS))
		else $error("scan channel out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_W'(SETTLE_STEPS))
		else $error("phase count past settling");

	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(dark_done || lit_done) |-> (state_q == ST_FDIV) && (dark_done == lit_done))
		else $error("divider result outside filter wait");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser && m_tlast) |-> (out_q.sensor_index == CHAN_W'(CHANNELS - 1)))
		else $error("report burst ended on wrong channel");

endmodule

`default_nettype wire

@@ tb/sv/led_modulated_reflectance_scanner_tb.sv @@
// Self-checking testbench for the LED-modulated reflectance scanner.
`timescale 1ns / 100ps

module led_modulated_reflectance_scanner_tb
	import lmrs_pkg::*;
();

	localparam int CHANNELS     = 10;
	localparam int SETTLE_STEPS = 4;
	localparam int CYCLE_LIMIT  = 600_000;
	localparam int PHASE_ITEMS  = 43;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;

	// indexes past the register list; the block must ignore them
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	led_modulated_reflectance_scanner #(
		.CHANNELS    (CHANNELS),
		.SETTLE_STEPS(SETTLE_STEPS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Scanner prediction: register copies and per-channel stores
	// ------------------------------------------------------------------
	led_mode_t           mode_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CHAN_W-1:0]   chan_q;
	logic                led_q;
	logic [PATTERN_W-1:0] pattern_q;
	logic [DARK_W-1:0]   dark_raw [CHANNELS];
	logic [SAMPLE_W-1:0] lit_raw  [CHANNELS];
	logic [DARK_W-1:0]   dark_avg [CHANNELS];
	logic [SAMPLE_W-1:0] lit_avg  [CHANNELS];

	out_item_t           scan_results_due [$];   // predicted results, oldest first
	logic [SAMPLE_W-1:0] conversions_pending [$]; // ADC samples still to send

	int  bad_results = 0;
	bit  stall_on = 1'b1;      // random idling on both sides
	bit  hold_armed = 1'b0;    // starts the long receiver hold-off
	logic m_hold = 1'b0;
	int  send_gap = 0;
	int  recv_gap = 0;
	bit  send_keep;
	int  cycle_count = 0;

	function automatic logic [SAMPLE_W-1:0] clipped_gap(int a, int b);
		int d;
		d = a - b;
		if (d < 0)
			return '0;
		if (d > int'(CLIP_MAX))
			return CLIP_MAX;
		return d[SAMPLE_W-1:0];
	endfunction

	task automatic clear_scan();
		int i;
		phase_q   = '0;
		chan_q    = '0;
		led_q     = 1'b0;
		pattern_q = PATTERN_INIT;
		for (i = 0; i < CHANNELS; i++) begin
			dark_raw[i] = DARK_INIT;
			lit_raw[i]  = '0;
			dark_avg[i] = DARK_INIT;
			lit_avg[i]  = '0;
		end
	endtask

	// One accepted conversion: advance the scan, queue what it emits.
	task automatic advance_scan(input logic [SAMPLE_W-1:0] sample);
		out_item_t r;
		int        i;
		int        k;
		k = int'(weight_q);
		if (phase_q == 0) begin
			// scan start: sample dropped, LED picked, all channels filtered
			case (mode_q)
				MODE_OFF: led_q = 1'b0;
				MODE_ON:  led_q = 1'b1;
				MODE_ALT: begin
					pattern_q = pattern_q + 1'b1;
					led_q     = pattern_q[0];
				end
				default: begin
					pattern_q = {pattern_q[2:0], pattern_q[3] ^ pattern_q[2]};
					led_q     = pattern_q[0];
				end
			endcase
			chan_q  = '0;
			phase_q = PHASE_W'(1);
			for (i = 0; i < CHANNELS; i++) begin
				dark_avg[i] = DARK_W'((k * int'(dark_avg[i]) + int'(dark_raw[i])) / (k + 1));
				lit_avg[i]  = SAMPLE_W'((k * int'(lit_avg[i]) + int'(lit_raw[i])) / (k + 1));
			end
			for (i = 0; i < CHANNELS; i++) begin
				r.next_channel        = chan_q;
				r.led_drive           = led_q;
				r.report_valid        = 1'b1;
				r.sensor_index        = CHAN_W'(i);
				r.raw_difference      = clipped_gap(dark_raw[i], lit_raw[i]);
				r.filtered_difference = clipped_gap(dark_avg[i], lit_avg[i]);
				r.last                = (i == CHANNELS - 1);
				scan_results_due.push_back(r);
			end
			return;
		end
		if (phase_q < SETTLE_STEPS) begin
			phase_q = phase_q + 1'b1;
		end else begin
			if (chan_q < CHANNELS) begin
				if (led_q)
					lit_raw[chan_q] = sample;
				else
					dark_raw[chan_q] = {1'b0, sample};
			end
			if (int'(chan_q) + 1 >= CHANNELS) begin
				phase_q = '0;
				chan_q  = '0;
			end else begin
				chan_q = chan_q + 1'b1;
			end
		end
		r = '0;
		r.next_channel = chan_q;
		r.led_drive    = led_q;
		r.last         = 1'b1;
		scan_results_due.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued samples, random gaps between requests
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			send_keep = 1'b0;
			if (s_tvalid && s_tready) begin
				advance_scan(s_tdata[SAMPLE_W-1:0]);
				void'(conversions_pending.pop_front());
			end else if (s_tvalid) begin
				send_keep = 1'b1;   // request not taken yet, hold it
			end
			if (send_keep) begin
				s_tvalid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (conversions_pending.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 16);
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, conversions_pending[0]};
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result request, random stalls on tready
	// ------------------------------------------------------------------
	task automatic check_result();
		out_item_t got;
		out_item_t want;
		got.next_channel        = m_tdata[3:0];
		got.led_drive           = m_tdata[4];
		got.sensor_index        = m_tdata[8:5];
		got.raw_difference      = m_tdata[20:9];
		got.filtered_difference = m_tdata[32:21];
		got.report_valid        = m_tuser;
		got.last                = m_tlast;
		if (scan_results_due.size() == 0) begin
			bad_results++;
			if (bad_results <= 10)
				$display("unexpected result: %p", got);
			return;
		end
		want = scan_results_due.pop_front();
		if (got.next_channel !== want.next_channel || got.led_drive !== want.led_drive ||
				got.report_valid !== want.report_valid ||
				got.sensor_index !== want.sensor_index ||
				got.raw_difference !== want.raw_difference ||
				got.filtered_difference !== want.filtered_difference ||
				got.last !== want.last) begin
			bad_results++;
			if (bad_results <= 10)
				$display("result mismatch:\n  expected %p\n  actual   %p", want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else begin
				m_tready <= !m_hold;
			end
		end
	end

	// long receiver hold-off: the block has to back up onto s_tready
	initial begin
		wait (hold_armed);
		@(posedge clk);
		m_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		m_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (index)
			REG_LED_MODE: begin
				clear_scan();
				mode_q = led_mode_t'(data[1:0]);
			end
			REG_FILTER_WEIGHT: weight_q = data;
			default: ;
		endcase
	endtask

	// bias toward the sample extremes, rest uniform
	task automatic queue_conversions(input int count);
		int n;
		int pick;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 7);
			if (pick == 0)
				conversions_pending.push_back('0);
			else if (pick == 1)
				conversions_pending.push_back(CLIP_MAX);
			else
				conversions_pending.push_back(SAMPLE_W'($urandom_range(0, 4095)));
		end
	endtask

	task automatic wait_drained();
		while (conversions_pending.size() > 0 || scan_results_due.size() > 0 || s_tvalid)
			@(posedge clk);
	endtask

	logic [SAMPLE_W-1:0] dark_reads [CHANNELS] = '{12'd0, 12'd4095, 12'h800, 12'h7FF,
		12'd1, 12'd4094, 12'hAAA, 12'h555, 12'd100, 12'd2000};
	logic [SAMPLE_W-1:0] lit_reads  [CHANNELS] = '{12'd4095, 12'd0, 12'h7FF, 12'h800,
		12'd4095, 12'd0, 12'h555, 12'hAAA, 12'd3000, 12'd2000};
	led_mode_t plan_mode [7] = '{MODE_LFSR, MODE_OFF, MODE_ON, MODE_ALT, MODE_LFSR,
		MODE_ALT, MODE_ALT};

	initial begin
		int          p;
		int          i;
		logic [31:0] junk;
		led_mode_t   m;
		mode_q   = MODE_INIT;
		weight_q = WEIGHT_INIT;
		clear_scan();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings (alternate mode, weight 7):
		// scan 1 LED off stores dark samples, scan 2 LED on stores lit
		// samples, some above dark to hit the low clip; the first start
		// reports the high clip of the 4096 dark reset value.
		conversions_pending.push_back(CLIP_MAX);   // start, sample dropped
		conversions_pending.push_back(12'hAAA);
		conversions_pending.push_back(12'h555);
		conversions_pending.push_back(12'd0);
		for (i = 0; i < CHANNELS; i++)
			conversions_pending.push_back(dark_reads[i]);
		conversions_pending.push_back(12'd0);      // start
		conversions_pending.push_back(12'hFFF);
		conversions_pending.push_back(12'h000);
		conversions_pending.push_back(12'h5A5);
		for (i = 0; i < CHANNELS; i++)
			conversions_pending.push_back(lit_reads[i]);
		conversions_pending.push_back(12'h123);    // start, both halves filled
		wait_drained();

		// Random phases across modes and weights. Phase 5 leaves the mode
		// alone (state carries over) and pokes the unused indexes instead.
		// Phase 4 carries the long hold-off; the last phase has no idling.
		for (p = 0; p < 7; p++) begin
			junk = $urandom;
			m    = (p == 6) ? led_mode_t'($urandom_range(0, 3)) : plan_mode[p];
			if (p != 5) begin
				write_reg(REG_LED_MODE, {junk[5:0], m});
			end else begin
				write_reg(REG_SPARE_A, junk[7:0]);
				write_reg(REG_SPARE_B, ~junk[7:0]);
			end
			case (p)
				0: write_reg(REG_FILTER_WEIGHT, 8'd0);
				1: write_reg(REG_FILTER_WEIGHT, 8'd255);
				2: write_reg(REG_FILTER_WEIGHT, 8'd1);
				default: write_reg(REG_FILTER_WEIGHT, junk[15:8]);
			endcase
			stall_on = (p < 6);
			if (p == 4)
				hold_armed = 1'b1;
			queue_conversions(PHASE_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
